// ===== hw/rtl/ctlq_pkg.sv =====
// ----------------------------------------------------------------------------
// ctlq_pkg
// Types, codes and constants shared by the carrier and tone lock qualifier.
// ----------------------------------------------------------------------------
package ctlq_pkg;

	// Command codes
	localparam logic [1:0] FUNC_START   = 2'd0;
	localparam logic [1:0] FUNC_TICK    = 2'd1;
	localparam logic [1:0] FUNC_CARRIER = 2'd2;
	localparam logic [1:0] FUNC_CODE    = 2'd3;

	// Search phases as shown on the result
	localparam logic [2:0] PH_CARRIER      = 3'd0;
	localparam logic [2:0] PH_CODE         = 3'd1;
	localparam logic [2:0] PH_FOUND        = 3'd2;
	localparam logic [2:0] PH_CODE_FAIL    = 3'd3;
	localparam logic [2:0] PH_CARRIER_FAIL = 3'd4;

	// Code kinds
	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_TONE    = 2'd1;
	localparam logic [1:0] KIND_DIGITAL = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_SINGLE_FREQ  = 2'd0;
	localparam logic [1:0] REG_TIMEOUT      = 2'd1;
	localparam logic [1:0] REG_FREQ_TO_EN   = 2'd2;
	localparam logic [1:0] REG_CODE_TO_EN   = 2'd3;

	localparam logic [31:0] NEAR_LIMIT      = 32'd100;
	localparam logic [1:0]  HITS_NEEDED     = 2'd3;
	localparam logic [7:0]  NO_CODE         = 8'hFF;
	localparam logic [31:0] NO_FREQ         = 32'hFFFF_FFFF;
	localparam logic [15:0] TIMER_MAX       = 16'hFFFF;
	localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;

	typedef struct packed {
		logic [1:0]  func;
		logic [26:0] frequency;
		logic [1:0]  code_kind;
		logic [7:0]  code_index;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [31:0] locked_frequency;
		logic [1:0]  result_kind;
		logic [7:0]  result_code;
		logic        result_valid;
		logic        alert;
	} res_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [15:0] value;
	} cfg_wr_t;

	typedef struct packed {
		logic        single_freq_mode;
		logic [15:0] timeout_ticks;
		logic        freq_timeout_enable;
		logic        code_timeout_enable;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [31:0] held_freq;
		logic [1:0]  hit_count;
		logic [1:0]  cand_kind;
		logic [7:0]  cand_code;
		logic        cand_valid;
		logic [15:0] tick_timer;
	} srch_state_t;

endpackage

// ===== hw/rtl/ctlq_chan_if.sv =====
// ----------------------------------------------------------------------------
// ctlq_chan_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface ctlq_chan_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/carrier_and_tone_lock_qualifier_core.sv =====
// ----------------------------------------------------------------------------
// carrier_and_tone_lock_qualifier_core
// Carrier and squelch-code lock qualifier for a radio search.
// ----------------------------------------------------------------------------
// Takes one command (start, tick, carrier reading or code reading) per clock
// and returns one result per command, in order. A command passes through the
// input register, then the search state and the result register are updated
// together once the result register is free or being emptied, and the result
// is held there until it is taken. One command per cycle is sustained as long
// as results are taken; the single result register sets that figure, and a
// held result stalls the command side. Configuration writes take effect on the
// cycle after their transfer and are accepted every cycle.
module carrier_and_tone_lock_qualifier_core (
	input  logic      clk,
	input  logic      arst_n,
	ctlq_chan_if.sink   cmd,
	ctlq_chan_if.source res,
	ctlq_chan_if.sink   cfg
);
	import ctlq_pkg::*;

	cfg_t        regs;
	logic        valid_s1;
	cmd_t        cmd_s1;
	logic        advance;
	srch_state_t state_q;
	srch_state_t state_nxt;
	logic        alert_nxt;
	logic        res_valid_q;
	res_t        res_q;

	ctlq_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	ctlq_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (cmd_s1)
	);

	ctlq_step u_step (
		.cmd   (cmd_s1),
		.regs  (regs),
		.cur   (state_q),
		.nxt   (state_nxt),
		.alert (alert_nxt)
	);

	// Move a command on when the result register is free or being emptied
	assign advance = valid_s1 && (!res_valid_q || res.ready);

	// Search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= PH_CARRIER;
			state_q.held_freq  <= NO_FREQ;
			state_q.hit_count  <= 2'd0;
			state_q.cand_kind  <= KIND_NONE;
			state_q.cand_code  <= NO_CODE;
			state_q.cand_valid <= 1'b0;
			state_q.tick_timer <= 16'd0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= advance || (res_valid_q && !res.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.phase            <= state_nxt.phase;
			res_q.locked_frequency <= state_nxt.held_freq;
			res_q.result_kind      <= state_nxt.cand_kind;
			res_q.result_code      <= state_nxt.cand_code;
			res_q.result_valid     <= state_nxt.cand_valid;
			res_q.alert            <= alert_nxt;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;
endmodule

// ===== hw/rtl/ctlq_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ctlq_cfg_regs
// Configuration register file, written through its own channel.
// ----------------------------------------------------------------------------
module ctlq_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	ctlq_chan_if.sink      cfg,
	output ctlq_pkg::cfg_t regs
);
	import ctlq_pkg::*;

	cfg_t regs_q;

	// Always able to take a write
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Update the addressed register on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.single_freq_mode    <= 1'b0;
			regs_q.timeout_ticks       <= TIMEOUT_RESET;
			regs_q.freq_timeout_enable <= 1'b0;
			regs_q.code_timeout_enable <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_SINGLE_FREQ: regs_q.single_freq_mode    <= cfg.data.value[0];
				REG_TIMEOUT:     regs_q.timeout_ticks       <= cfg.data.value;
				REG_FREQ_TO_EN:  regs_q.freq_timeout_enable <= cfg.data.value[0];
				REG_CODE_TO_EN:  regs_q.code_timeout_enable <= cfg.data.value[0];
				default: begin
				end
			endcase
		end
	end
endmodule

// ===== hw/rtl/ctlq_in_reg.sv =====
// ----------------------------------------------------------------------------
// ctlq_in_reg
// Input register stage: holds one command until the update logic takes it.
// ----------------------------------------------------------------------------
module ctlq_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	ctlq_chan_if.sink      cmd,
	input  logic           advance,
	output logic           valid_s1,
	output ctlq_pkg::cmd_t data_s1
);
	import ctlq_pkg::*;

	logic take;

	// Free when empty or emptying this cycle
	assign cmd.ready = !valid_s1 || advance;
	assign take      = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && !advance);
		end
	end

	// Load the payload on a transfer
	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= cmd.data;
		end
	end
endmodule

// ===== hw/rtl/ctlq_step.sv =====
// ----------------------------------------------------------------------------
// ctlq_step
// Next-state logic of the search for one command.
// ----------------------------------------------------------------------------
module ctlq_step (
	input  ctlq_pkg::cmd_t      cmd,
	input  ctlq_pkg::cfg_t      regs,
	input  ctlq_pkg::srch_state_t cur,
	output ctlq_pkg::srch_state_t nxt,
	output logic                alert
);
	import ctlq_pkg::*;

	logic [31:0] freq_ext;
	logic [31:0] diff;
	logic [31:0] offset_mag;
	logic        near;
	logic [1:0]  hit_inc;

	// Distance from the held frequency, two's complement magnitude
	assign freq_ext   = {5'd0, cmd.frequency};
	assign diff       = freq_ext - cur.held_freq;
	assign offset_mag = diff[31] ? (32'd0 - diff) : diff;
	assign near       = offset_mag < NEAR_LIMIT;
	assign hit_inc    = (cur.hit_count < HITS_NEEDED) ? cur.hit_count + 2'd1 : HITS_NEEDED;

	always_comb begin
		logic done;
		logic fail_en;
		done    = 1'b0;
		fail_en = 1'b0;
		nxt     = cur;
		alert   = 1'b0;

		// Start, or count a tick
		if (cmd.func == FUNC_START) begin
			nxt.phase      = regs.single_freq_mode ? PH_CODE : PH_CARRIER;
			nxt.held_freq  = regs.single_freq_mode ? freq_ext : NO_FREQ;
			nxt.cand_kind  = KIND_NONE;
			nxt.cand_code  = NO_CODE;
			nxt.cand_valid = 1'b0;
			nxt.hit_count  = 2'd0;
			nxt.tick_timer = 16'd0;
			done           = 1'b1;
		end else if (cmd.func == FUNC_TICK && cur.tick_timer != TIMER_MAX) begin
			nxt.tick_timer = cur.tick_timer + 16'd1;
		end

		// Fail a running phase once the timer reaches its limit and its timeout applies
		if (!done && (cur.phase == PH_CARRIER || cur.phase == PH_CODE)
				&& nxt.tick_timer >= regs.timeout_ticks) begin
			if (cur.phase == PH_CARRIER) begin
				fail_en = regs.single_freq_mode ? regs.code_timeout_enable
					: regs.freq_timeout_enable;
				if (fail_en) begin
					nxt.phase = PH_CARRIER_FAIL;
					alert     = 1'b1;
					done      = 1'b1;
				end
			end else if (regs.code_timeout_enable || !regs.single_freq_mode) begin
				nxt.phase = PH_CODE_FAIL;
				alert     = 1'b1;
				done      = 1'b1;
			end
		end

		// Carrier readings: count close readings, lock on the third
		if (!done && cmd.func == FUNC_CARRIER && cur.phase == PH_CARRIER) begin
			nxt.hit_count = near ? hit_inc : 2'd0;
			nxt.held_freq = freq_ext;
			if (near && hit_inc == HITS_NEEDED) begin
				nxt.cand_kind  = KIND_NONE;
				nxt.cand_code  = NO_CODE;
				nxt.cand_valid = 1'b0;
				nxt.hit_count  = 2'd0;
				nxt.tick_timer = 16'd0;
				nxt.phase      = PH_CODE;
				alert          = 1'b1;
			end
		end else if (!done && cmd.func == FUNC_CODE && cur.phase == PH_CODE) begin
			// Code readings: digital locks at once, tone after three alike
			if (cmd.code_kind == KIND_DIGITAL || cmd.code_kind == KIND_TONE) begin
				if (cmd.code_index == NO_CODE) begin
					nxt.cand_kind  = KIND_NONE;
					nxt.cand_code  = NO_CODE;
					nxt.cand_valid = 1'b0;
					nxt.hit_count  = 2'd0;
				end else if (cmd.code_kind == KIND_DIGITAL) begin
					nxt.hit_count  = 2'd0;
					nxt.cand_kind  = KIND_DIGITAL;
					nxt.cand_code  = cmd.code_index;
					nxt.cand_valid = 1'b1;
					nxt.phase      = PH_FOUND;
					alert          = 1'b1;
				end else if (cmd.code_index == cur.cand_code
						&& cur.cand_kind == KIND_TONE) begin
					nxt.hit_count = hit_inc;
					if (hit_inc == HITS_NEEDED) begin
						nxt.phase      = PH_FOUND;
						nxt.cand_valid = 1'b1;
						alert          = 1'b1;
					end
				end else begin
					nxt.hit_count  = 2'd1;
					nxt.cand_kind  = KIND_TONE;
					nxt.cand_code  = cmd.code_index;
					nxt.cand_valid = 1'b0;
				end
			end
		end
	end
endmodule

// ===== hw/rtl/ctlq_checker.sv =====
// ----------------------------------------------------------------------------
// ctlq_checker
// Port-level checks on the qualifier's results, bound to the top level.
// ----------------------------------------------------------------------------
module ctlq_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            res_valid,
	input logic            res_ready,
	input ctlq_pkg::res_t  res_data
);
	import ctlq_pkg::*;

	// Hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// A confirmed code goes with the found phase, and only with it
	a_valid_found: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.result_valid == (res_data.phase == PH_FOUND)))
		else $error("result_valid does not match found phase");

	// Carrier search never carries a code candidate
	a_carrier_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.phase == PH_CARRIER
		|-> res_data.result_kind == KIND_NONE && res_data.result_code == NO_CODE)
		else $error("candidate present in carrier search");

	// A found result holds a real code
	a_found_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.phase == PH_FOUND
		|-> res_data.result_code != NO_CODE
			&& (res_data.result_kind == KIND_TONE || res_data.result_kind == KIND_DIGITAL))
		else $error("found without a code");
endmodule

bind carrier_and_tone_lock_qualifier_core ctlq_checker u_ctlq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
